// ----- hdl/srl_pkg.sv -----
`default_nettype none
package srl_pkg;

  // request codes carried on the input tuser
  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_PREPEND    = 3'd1,
    OP_SORTED     = 3'd2,
    OP_DROP_LAST  = 3'd3,
    OP_DROP_FIRST = 3'd4,
    OP_REMOVE_KEY = 3'd5,
    OP_READ_POS   = 3'd6,
    OP_READ_KEY   = 3'd7
  } op_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned FieldW = 6;

  // one stored record
  typedef struct packed {
    logic signed [WordW-1:0] key;
    logic [WordW-1:0]        grade_one;
    logic [WordW-1:0]        grade_two;
    logic [WordW-1:0]        grade_three;
  } rec_t;

  // controls broadcast to every cell of the row
  typedef struct packed {
    op_e                     op;
    logic                    eval;
    logic signed [WordW-1:0] eval_key;
    logic                    write;
    rec_t                    new_rec;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/sorted_record_list.sv -----
// a request is taken only when idle, where each cell stores compare flags;
//   its result is registered in the commit state, once the output is free,
//   as the target mark ripples through the cells; only then is it idle again
// reset: asynchronous, active low; clears the count, the state and the output
//   valid; record storage is not cleared
`default_nettype none
module sorted_record_list #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // key[31:0], grade_one[63:32], grade_two[95:64], grade_three[127:96],
  // position[133:128], zero fill
  input  wire  [135:0] s_axis_tdata,
  // req_type[2:0]
  input  wire  [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // ok[0], found_key[32:1], found_grade_one[64:33], found_grade_two[96:65],
  // found_grade_three[128:97], count[134:129], full_res[135], empty_res[136],
  // zero fill
  output logic [143:0] m_axis_tdata
);
  import srl_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > FieldW) ? CW : FieldW;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_COMMIT = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  op_e           op_q;
  rec_t          new_rec_q;
  logic [FieldW-1:0] pos_q;

  logic s_fire, commit;
  logic ok;
  cell_ctrl_t ctrl;

  logic [CAPACITY-1:0] live, past_count, pos_hit;
  logic [CAPACITY:0]   ag;
  rec_t cell_rec [CAPACITY];
  rec_t rd_chain [CAPACITY+1];

  logic        out_ok_q, out_full_q, out_empty_q;
  rec_t        out_rec_q;
  logic [FieldW-1:0] out_count_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign commit        = (state_q == ST_COMMIT) & (~m_axis_tvalid | m_axis_tready);

  // request hold register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q                  <= op_e'(s_axis_tuser);
      new_rec_q.key         <= s_axis_tdata[31:0];
      new_rec_q.grade_one   <= s_axis_tdata[63:32];
      new_rec_q.grade_two   <= s_axis_tdata[95:64];
      new_rec_q.grade_three <= s_axis_tdata[127:96];
      pos_q                 <= s_axis_tdata[133:128];
    end
  end

  // broadcast controls
  always_comb begin
    ctrl.op       = op_q;
    ctrl.eval     = s_fire;
    ctrl.eval_key = s_axis_tdata[31:0];
    ctrl.write    = commit & ok;
    ctrl.new_rec  = new_rec_q;
  end

  // row of cells
  assign ag[0]       = 1'b0;
  assign rd_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign past_count[i] = (CW'(i) >= count_q);
    assign live[i]       = ~past_count[i];
    assign pos_hit[i]    = live[i] & (PW'(pos_q) == PW'(i + 1));

    srl_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .live_i       (live[i]),
      .past_count_i (past_count[i]),
      .pos_hit_i    (pos_hit[i]),
      .ag_i         (ag[i]),
      .ag_o         (ag[i+1]),
      .left_i       ((i == 0) ? new_rec_q : cell_rec[(i == 0) ? 0 : i - 1]),
      .right_i      ((i == CAPACITY - 1) ? cell_rec[i]
                                         : cell_rec[(i == CAPACITY - 1) ? i : i + 1]),
      .rec_o        (cell_rec[i]),
      .rd_i         (rd_chain[i]),
      .rd_o         (rd_chain[i+1])
    );
  end

  // success and count update
  always_comb begin
    ok      = 1'b0;
    count_d = count_q;
    case (op_q)
      OP_APPEND, OP_PREPEND, OP_SORTED: begin
        ok = (count_q != CW'(CAPACITY));
        if (ok) count_d = count_q + CW'(1);
      end
      OP_DROP_LAST, OP_DROP_FIRST: begin
        ok = (count_q != '0);
        if (ok) count_d = count_q - CW'(1);
      end
      OP_REMOVE_KEY: begin
        ok = ag[CAPACITY];
        if (ok) count_d = count_q - CW'(1);
      end
      default: ok = ag[CAPACITY];
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_fire) state_d = ST_COMMIT;
      ST_COMMIT: if (commit) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q       <= count_d;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_ok_q    <= ok;
      out_rec_q   <= rd_chain[CAPACITY];
      out_count_q <= FieldW'(count_d);
      out_full_q  <= (count_d == CW'(CAPACITY));
      out_empty_q <= (count_d == '0);
    end
  end

  assign m_axis_tdata = {7'd0, out_empty_q, out_full_q, out_count_q,
                         out_rec_q.grade_three, out_rec_q.grade_two,
                         out_rec_q.grade_one, out_rec_q.key, out_ok_q};

endmodule
`default_nettype wire

// ----- hdl/srl_cell.sv -----
`default_nettype none
module srl_cell (
  input  wire              clk_i,
  input  wire srl_pkg::cell_ctrl_t ctrl_i,
  input  wire              live_i,
  input  wire              past_count_i,
  input  wire              pos_hit_i,
  input  wire              ag_i,
  output logic             ag_o,
  input  wire srl_pkg::rec_t left_i,
  input  wire srl_pkg::rec_t right_i,
  output srl_pkg::rec_t    rec_o,
  input  wire srl_pkg::rec_t rd_i,
  output srl_pkg::rec_t    rd_o
);
  import srl_pkg::*;

  rec_t rec_q, rec_d;
  logic lt_q, eq_q;
  logic hit, first, rd_sel;

  // compare flags taken when the request is accepted
  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      lt_q <= rec_q.key < ctrl_i.eval_key;
      eq_q <= rec_q.key == ctrl_i.eval_key;
    end
  end

  // local hit, chained into the running "at or after the target" mark
  always_comb begin
    case (ctrl_i.op)
      OP_APPEND:     hit = past_count_i;
      OP_PREPEND:    hit = 1'b1;
      OP_SORTED:     hit = (live_i & ~lt_q) | past_count_i;
      OP_DROP_LAST:  hit = 1'b0;
      OP_DROP_FIRST: hit = 1'b1;
      OP_REMOVE_KEY: hit = live_i & eq_q;
      OP_READ_POS:   hit = pos_hit_i;
      OP_READ_KEY:   hit = live_i & eq_q;
      default:       hit = 1'b0;
    endcase
  end

  assign ag_o  = ag_i | hit;
  assign first = ag_o & ~ag_i;

  // shift up on inserts, down on first-record and by-key removals
  always_comb begin
    rec_d = rec_q;
    case (ctrl_i.op)
      OP_APPEND, OP_PREPEND, OP_SORTED: begin
        if (first) begin
          rec_d = ctrl_i.new_rec;
        end else if (ag_i) begin
          rec_d = left_i;
        end
      end
      OP_DROP_FIRST, OP_REMOVE_KEY: begin
        if (ag_o) begin
          rec_d = right_i;
        end
      end
      default: rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      rec_q <= rec_d;
    end
  end

  // read chain: the selected record is or-ed onto the passing word
  assign rd_sel = first & ((ctrl_i.op == OP_READ_POS) | (ctrl_i.op == OP_READ_KEY));
  assign rd_o   = rd_i | (rd_sel ? rec_q : '0);
  assign rec_o  = rec_q;

endmodule
`default_nettype wire
